/* rtl/core/lcgs_pkg.sv */
// shared constants for the lda collapsed gibbs token sampler
// no dependencies
package lcgs_pkg;
    localparam int MAX_TOPICS = 256;
    localparam int MAX_DOCS   = 1024;
    localparam int MAX_VOCAB  = 4096;
    localparam int MAX_TOKENS = 65536;

    localparam int TOPIC_W = $clog2(MAX_TOPICS);
    localparam int DOC_W   = $clog2(MAX_DOCS);
    localparam int VOCAB_W = $clog2(MAX_VOCAB);
    localparam int SLOT_W  = $clog2(MAX_TOKENS);
    localparam int NTOP_W  = TOPIC_W + 1;

    localparam int DTC_DEPTH = MAX_DOCS * MAX_TOPICS;
    localparam int TWC_DEPTH = MAX_TOPICS * MAX_VOCAB;
    localparam int DTC_AW    = DOC_W + TOPIC_W;
    localparam int TWC_AW    = TOPIC_W + VOCAB_W;

    localparam int CNT_W  = 16;
    localparam int TOT_W  = 24;
    localparam int WGT_W  = 48;
    localparam int OPA_W  = 33;
    localparam int DEN_W  = 41;
    localparam int QUO_W  = 63;
    localparam int PROD_W = 65;

    localparam logic [WGT_W-1:0] WGT_MAX = '1;
endpackage

/* rtl/core/lda_collapsed_gibbs_token_sampler_unit.sv */
// lda collapsed gibbs token sampler, top level
// depends on lcgs_pkg and lcgs_ram
//
// One token per input transfer. A resample item forms each active topic's weight
// with a 63-step restoring divider, then searches the cumulative weight ram topic
// by topic, stopping at the first topic whose sum reaches the target or at the
// last active topic. After reset the block sweeps all count rams to zero and
// stalls input meanwhile; configuration writes are taken at all times. The next
// item is taken while a finished result still waits in the output register.
module lda_collapsed_gibbs_token_sampler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [9:0]  i_doc_index,
    input  logic [15:0] i_token_slot,
    input  logic [11:0] i_word_id,
    input  logic [7:0]  i_initial_topic,
    input  logic [15:0] i_random_fraction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_old_topic,
    output logic [7:0]  o_new_topic
);
    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_NTOP  = 2'd2,
        REG_VOCAB = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_MOD, S_VB, S_TT_RD, S_OLD, S_DEC_RD, S_DEC_WR,
        S_K_RD, S_K_LD, S_DIV, S_M0, S_M1, S_ACC, S_T0, S_T1, S_T2,
        S_S_RD, S_S_CMP, S_INC_RD, S_INC_WR, S_DONE
    } t_state;

    t_state r_state;

    logic [23:0] r_alpha, r_beta;
    logic [8:0]  r_ntop;
    logic [12:0] r_vocab;

    logic [lcgs_pkg::TWC_AW-1:0]  r_clr;
    logic [lcgs_pkg::DOC_W-1:0]   r_doc;
    logic [lcgs_pkg::SLOT_W-1:0]  r_slot;
    logic [lcgs_pkg::VOCAB_W-1:0] r_word;
    logic [lcgs_pkg::TOPIC_W-1:0] r_init, r_old, r_new;
    logic [15:0]                  r_u;
    logic [lcgs_pkg::NTOP_W-1:0]  r_k;
    logic [5:0]                   r_cnt;
    logic [36:0]                  r_vb;
    logic [lcgs_pkg::OPA_W-1:0]   r_a;
    logic [lcgs_pkg::DEN_W-1:0]   r_dvs;
    logic [lcgs_pkg::DEN_W:0]     r_rem;
    logic [lcgs_pkg::QUO_W-1:0]   r_quo;
    logic [lcgs_pkg::PROD_W-1:0]  r_mlo, r_mhi;
    logic [lcgs_pkg::WGT_W-1:0]   r_sum, r_target;
    logic                         r_out_valid;
    logic [7:0]                   r_out_old, r_out_new;

    logic [lcgs_pkg::NTOP_W-1:0]  kact;
    logic [lcgs_pkg::TOPIC_W-1:0] tsel;
    logic [lcgs_pkg::OPA_W-1:0]   mul_a;
    logic [31:0]                  mul_b;
    logic [lcgs_pkg::PROD_W-1:0]  mul_p;
    logic                         cfg_we;

    logic                         dtc_we, twc_we, tt_we, tok_we, cw_we;
    logic [lcgs_pkg::DTC_AW-1:0]  dtc_addr;
    logic [lcgs_pkg::TWC_AW-1:0]  twc_addr;
    logic [lcgs_pkg::TOPIC_W-1:0] tt_addr;
    logic [15:0]                  dtc_wdata, twc_wdata, dtc_rdata, twc_rdata;
    logic [23:0]                  tt_wdata, tt_rdata;
    logic [7:0]                   tok_rdata;
    logic [lcgs_pkg::WGT_W-1:0]   cw_rdata, cw_wdata;

    logic [lcgs_pkg::DEN_W-1:0]   den;
    logic [lcgs_pkg::DEN_W:0]     rem_sh;
    logic                         rem_ge;
    logic                         w_sat;
    logic [65:0]                  w_add;
    logic [lcgs_pkg::WGT_W-1:0]   w_val;
    logic [lcgs_pkg::WGT_W:0]     sum_add;
    logic [63:0]                  tgt_add;
    logic                         mod_ge;

    assign pready     = 1'b1;
    assign cfg_we     = psel & penable & pwrite;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_old_topic = r_out_old;
    assign o_new_topic = r_out_new;

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_ALPHA: prdata = {8'b0, r_alpha};
            REG_BETA:  prdata = {8'b0, r_beta};
            REG_NTOP:  prdata = {23'b0, r_ntop};
            REG_VOCAB: prdata = {19'b0, r_vocab};
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        if (r_ntop == '0) begin
            kact = 9'd1;
        end else if (r_ntop > 9'(lcgs_pkg::MAX_TOPICS)) begin
            kact = 9'(lcgs_pkg::MAX_TOPICS);
        end else begin
            kact = r_ntop;
        end
    end

    // topic used for count addressing
    always_comb begin
        case (r_state)
            S_DEC_RD, S_DEC_WR: tsel = r_old;
            S_INC_RD, S_INC_WR: tsel = r_new;
            default:            tsel = r_k[lcgs_pkg::TOPIC_W-1:0];
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_VB: begin
                mul_a = {20'b0, r_vocab};
                mul_b = {8'b0, r_beta};
            end
            S_M0: begin
                mul_a = r_a;
                mul_b = r_quo[31:0];
            end
            S_M1: begin
                mul_a = r_a;
                mul_b = {1'b0, r_quo[62:32]};
            end
            S_T0: begin
                mul_a = {9'b0, r_sum[23:0]};
                mul_b = {16'b0, r_u};
            end
            default: begin
                mul_a = {9'b0, r_sum[47:24]};
                mul_b = {16'b0, r_u};
            end
        endcase
    end
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // count ram ports
    always_comb begin
        dtc_we    = 1'b0;
        twc_we    = 1'b0;
        tt_we     = 1'b0;
        dtc_addr  = {r_doc, tsel};
        twc_addr  = {tsel, r_word};
        tt_addr   = tsel;
        dtc_wdata = '0;
        twc_wdata = '0;
        tt_wdata  = '0;
        case (r_state)
            S_CLR: begin
                dtc_we   = 1'b1;
                twc_we   = 1'b1;
                tt_we    = 1'b1;
                dtc_addr = r_clr[lcgs_pkg::DTC_AW-1:0];
                twc_addr = r_clr;
                tt_addr  = r_clr[lcgs_pkg::TOPIC_W-1:0];
            end
            S_DEC_WR: begin
                dtc_we    = 1'b1;
                twc_we    = 1'b1;
                tt_we     = 1'b1;
                dtc_wdata = (dtc_rdata == '0) ? dtc_rdata : dtc_rdata - 16'd1;
                twc_wdata = (twc_rdata == '0) ? twc_rdata : twc_rdata - 16'd1;
                tt_wdata  = (tt_rdata == '0) ? tt_rdata : tt_rdata - 24'd1;
            end
            S_INC_WR: begin
                dtc_we    = 1'b1;
                twc_we    = 1'b1;
                tt_we     = 1'b1;
                dtc_wdata = (&dtc_rdata) ? dtc_rdata : dtc_rdata + 16'd1;
                twc_wdata = (&twc_rdata) ? twc_rdata : twc_rdata + 16'd1;
                tt_wdata  = (&tt_rdata) ? tt_rdata : tt_rdata + 24'd1;
            end
            default: ;
        endcase
    end

    assign tok_we = (r_state == S_INC_RD);
    assign cw_we  = (r_state == S_ACC);

    // weight datapath
    assign den    = 41'({tt_rdata, 16'b0}) + 41'(r_vb);
    assign rem_sh = {r_rem[lcgs_pkg::DEN_W-1:0], r_quo[lcgs_pkg::QUO_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});
    assign w_add  = 66'(r_mlo) + {2'b0, r_mhi[31:0], 32'b0};
    assign w_sat  = (|r_mhi[64:32]) | (|w_add[65:64]);
    assign w_val  = w_sat ? lcgs_pkg::WGT_MAX : w_add[63:16];
    assign sum_add = {1'b0, r_sum} + {1'b0, w_val};
    assign cw_wdata = sum_add[lcgs_pkg::WGT_W] ? lcgs_pkg::WGT_MAX
                                               : sum_add[lcgs_pkg::WGT_W-1:0];
    assign tgt_add = {r_mhi[39:0], 24'b0} + {24'b0, r_mlo[39:0]};
    assign mod_ge  = ({9'b0, r_init} >= (17'(kact) << r_cnt[2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_alpha     <= 24'd65536;
            r_beta      <= 24'd6554;
            r_ntop      <= 9'd256;
            r_vocab     <= 13'd4096;
        end else begin
            if (cfg_we) begin
                unique case (t_reg'(paddr[3:2]))
                    REG_ALPHA: r_alpha <= pwdata[23:0];
                    REG_BETA:  r_beta  <= pwdata[23:0];
                    REG_NTOP:  r_ntop  <= pwdata[8:0];
                    REG_VOCAB: r_vocab <= pwdata[12:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_doc   <= i_doc_index;
                        r_slot  <= i_token_slot;
                        r_word  <= i_word_id;
                        r_init  <= i_initial_topic;
                        r_u     <= i_random_fraction;
                        r_old   <= '0;
                        r_cnt   <= 6'd7;
                        r_state <= i_command ? S_VB : S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_ge) begin
                        r_init <= r_init - 8'(17'(kact) << r_cnt[2:0]);
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_INC_RD;
                    end
                end
                S_VB: begin
                    r_vb    <= mul_p[36:0];
                    r_state <= S_TT_RD;
                end
                S_TT_RD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_old   <= tok_rdata;
                    r_state <= S_DEC_RD;
                end
                S_DEC_RD: begin
                    r_state <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    r_k     <= '0;
                    r_sum   <= '0;
                    r_state <= S_K_RD;
                end
                S_K_RD: begin
                    r_state <= S_K_LD;
                end
                S_K_LD: begin
                    r_a     <= 33'({dtc_rdata, 16'b0}) + 33'(r_alpha);
                    r_quo   <= 63'({33'({twc_rdata, 16'b0}) + 33'(r_beta), 30'b0});
                    r_dvs   <= (den == '0) ? 41'd1 : den;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= rem_ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
                    r_quo <= {r_quo[lcgs_pkg::QUO_W-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(lcgs_pkg::QUO_W - 1)) begin
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    r_mlo   <= mul_p;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_mhi   <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= cw_wdata;
                    r_k   <= r_k + 1'b1;
                    if (r_k + 1'b1 == kact) begin
                        r_state <= S_T0;
                    end else begin
                        r_state <= S_K_RD;
                    end
                end
                S_T0: begin
                    r_mlo   <= mul_p;
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_mhi   <= mul_p;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_target <= tgt_add[63:16];
                    r_k      <= '0;
                    r_state  <= S_S_RD;
                end
                S_S_RD: begin
                    r_state <= S_S_CMP;
                end
                S_S_CMP: begin
                    if (cw_rdata >= r_target || r_k + 1'b1 == kact) begin
                        r_new   <= r_k[lcgs_pkg::TOPIC_W-1:0];
                        r_state <= S_INC_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_S_RD;
                    end
                end
                S_INC_RD: begin
                    r_state <= S_INC_WR;
                end
                S_INC_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_old   <= r_old;
                        r_out_new   <= r_new;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // assign path lands its reduced topic here
            if (r_state == S_MOD && r_cnt == '0) begin
                r_new <= mod_ge ? r_init - 8'(kact) : r_init;
            end
        end
    end

    lcgs_ram #(.WIDTH(8), .DEPTH(lcgs_pkg::MAX_TOKENS)) u_tok (
        .i_clk   (i_clk),
        .i_we    (tok_we),
        .i_waddr (r_slot),
        .i_wdata (r_new),
        .i_raddr (r_slot),
        .o_rdata (tok_rdata)
    );

    lcgs_ram #(.WIDTH(lcgs_pkg::CNT_W), .DEPTH(lcgs_pkg::DTC_DEPTH)) u_dtc (
        .i_clk   (i_clk),
        .i_we    (dtc_we),
        .i_waddr (dtc_addr),
        .i_wdata (dtc_wdata),
        .i_raddr (dtc_addr),
        .o_rdata (dtc_rdata)
    );

    lcgs_ram #(.WIDTH(lcgs_pkg::CNT_W), .DEPTH(lcgs_pkg::TWC_DEPTH)) u_twc (
        .i_clk   (i_clk),
        .i_we    (twc_we),
        .i_waddr (twc_addr),
        .i_wdata (twc_wdata),
        .i_raddr (twc_addr),
        .o_rdata (twc_rdata)
    );

    lcgs_ram #(.WIDTH(lcgs_pkg::TOT_W), .DEPTH(lcgs_pkg::MAX_TOPICS)) u_tt (
        .i_clk   (i_clk),
        .i_we    (tt_we),
        .i_waddr (tt_addr),
        .i_wdata (tt_wdata),
        .i_raddr (tt_addr),
        .o_rdata (tt_rdata)
    );

    lcgs_ram #(.WIDTH(lcgs_pkg::WGT_W), .DEPTH(lcgs_pkg::MAX_TOPICS)) u_cw (
        .i_clk   (i_clk),
        .i_we    (cw_we),
        .i_waddr (r_k[lcgs_pkg::TOPIC_W-1:0]),
        .i_wdata (cw_wdata),
        .i_raddr (r_k[lcgs_pkg::TOPIC_W-1:0]),
        .o_rdata (cw_rdata)
    );
endmodule

/* rtl/core/lcgs_ram.sv */
// generic simple dual port ram with registered read
// no dependencies
module lcgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* dv/tb_top.sv */
// testbench for lda_collapsed_gibbs_token_sampler_unit: directed table, then random
// token streams, each result checked against typed table pairs or a gibbs predictor
// depends on lcgs_pkg and the sampler rtl
`timescale 1ns / 100ps

module tb_top;
    typedef enum logic {CMD_ASSIGN = 1'b0, CMD_RESAMPLE = 1'b1} t_cmd;
    typedef enum logic [1:0] {REG_ALPHA = 2'd0, REG_BETA = 2'd1, REG_NTOPICS = 2'd2,
                              REG_VOCAB = 2'd3} t_reg_idx;
    typedef enum logic {ROW_CFG = 1'b0, ROW_ITEM = 1'b1} t_row;

    typedef struct packed {
        logic [7:0] old_topic;
        logic [7:0] drawn_topic;
    } t_topic_pair;

    typedef struct {
        t_row        kind;
        t_reg_idx    reg_idx;
        logic [31:0] reg_val;
        t_cmd        cmd;
        logic [9:0]  doc;
        logic [15:0] slot;
        logic [11:0] word;
        logic [7:0]  init;
        logic [15:0] frac;
        bit          typed;
        logic [7:0]  exp_old;
        logic [7:0]  exp_new;
    } t_stim_row;

    typedef struct {
        logic [15:0] slot;
        logic [9:0]  doc;
        logic [11:0] word;
    } t_token;

    localparam longint unsigned W_MAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam int unsigned C16 = 16'hFFFF;
    localparam int unsigned C24 = 24'hFFFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b0;
    logic [9:0]  i_doc_index = '0;
    logic [15:0] i_token_slot = '0;
    logic [11:0] i_word_id = '0;
    logic [7:0]  i_initial_topic = '0;
    logic [15:0] i_random_fraction = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_old_topic;
    logic [7:0]  o_new_topic;

    lda_collapsed_gibbs_token_sampler_unit dut (.*);

    // predictor state
    bit [15:0] doc_topic_tally [lcgs_pkg::MAX_DOCS*lcgs_pkg::MAX_TOPICS];
    bit [15:0] topic_word_tally [lcgs_pkg::MAX_TOPICS*lcgs_pkg::MAX_VOCAB];
    bit [23:0] topic_sum [lcgs_pkg::MAX_TOPICS];
    bit [7:0]  slot_topic [lcgs_pkg::MAX_TOKENS];
    bit [23:0] alpha_cfg = 24'd65536;
    bit [23:0] beta_cfg = 24'd6554;
    bit [8:0]  ntopics_cfg = 9'd256;
    bit [12:0] vocab_cfg = 13'd4096;

    t_topic_pair topic_pairs_due[$];
    t_token      live_tokens[$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("lda_collapsed_gibbs_token_sampler_unit test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic int unsigned active_topic_count();
        if (ntopics_cfg == 0) return 1;
        if (ntopics_cfg > lcgs_pkg::MAX_TOPICS) return lcgs_pkg::MAX_TOPICS;
        return ntopics_cfg;
    endfunction

    function automatic void bump_counts(input int unsigned doc, input int unsigned topic,
                                        input int unsigned word, input bit add);
        int unsigned di, wi;
        di = doc * lcgs_pkg::MAX_TOPICS + topic;
        wi = topic * lcgs_pkg::MAX_VOCAB + word;
        if (add) begin
            if (doc_topic_tally[di] < C16) doc_topic_tally[di]++;
            if (topic_word_tally[wi] < C16) topic_word_tally[wi]++;
            if (topic_sum[topic] < C24) topic_sum[topic]++;
        end else begin
            if (doc_topic_tally[di] > 0) doc_topic_tally[di]--;
            if (topic_word_tally[wi] > 0) topic_word_tally[wi]--;
            if (topic_sum[topic] > 0) topic_sum[topic]--;
        end
    endfunction

    function automatic longint unsigned topic_weight(input int unsigned doc,
                                                     input int unsigned topic,
                                                     input int unsigned word);
        longint unsigned a, b, d, r, p;
        a = (longint'(doc_topic_tally[doc*lcgs_pkg::MAX_TOPICS+topic]) << 16) + alpha_cfg;
        b = (longint'(topic_word_tally[topic*lcgs_pkg::MAX_VOCAB+word]) << 16) + beta_cfg;
        d = (longint'(topic_sum[topic]) << 16) + longint'(vocab_cfg) * beta_cfg;
        if (d == 0) d = 1;
        r = (b << 30) / d;
        if (r != 0 && a > 64'hFFFF_FFFF_FFFF_FFFF / r) return W_MAX;
        p = (a * r) >> 16;
        return (p > W_MAX) ? W_MAX : p;
    endfunction

    function automatic t_topic_pair gibbs_step(input t_cmd cmd, input logic [9:0] doc,
                                               input logic [15:0] slot,
                                               input logic [11:0] word,
                                               input logic [7:0] init,
                                               input logic [15:0] frac);
        int unsigned k_act, pick;
        longint unsigned sum, target;
        longint unsigned cum [lcgs_pkg::MAX_TOPICS];
        t_topic_pair res;
        k_act = active_topic_count();
        res.old_topic = '0;
        if (cmd == CMD_ASSIGN) begin
            pick = init % k_act;
        end else begin
            res.old_topic = slot_topic[slot];
            bump_counts(doc, res.old_topic, word, 1'b0);
            sum = 0;
            for (int k = 0; k < k_act; k++) begin
                sum += topic_weight(doc, k, word);
                if (sum > W_MAX) sum = W_MAX;
                cum[k] = sum;
            end
            target = (sum * frac) >> 16;
            pick = k_act - 1;
            for (int k = 0; k < k_act; k++) begin
                if (cum[k] >= target) begin
                    pick = k;
                    break;
                end
            end
        end
        slot_topic[slot] = 8'(pick);
        bump_counts(doc, pick, word, 1'b1);
        res.drawn_topic = 8'(pick);
        return res;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (topic_pairs_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ALPHA:   alpha_cfg = val[23:0];
            REG_BETA:    beta_cfg = val[23:0];
            REG_NTOPICS: ntopics_cfg = val[8:0];
            default:     vocab_cfg = val[12:0];
        endcase
    endtask

    task automatic send_token(input t_cmd cmd, input logic [9:0] doc, input logic [15:0] slot,
                              input logic [11:0] word, input logic [7:0] init,
                              input logic [15:0] frac, input bit typed,
                              input t_topic_pair typed_pair);
        t_topic_pair pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_doc_index <= doc;
        i_token_slot <= slot;
        i_word_id <= word;
        i_initial_topic <= init;
        i_random_fraction <= frac;
        do @(posedge i_clk); while (o_in_stall);
        pred = gibbs_step(cmd, doc, slot, word, init, frac);
        if (typed) pred = typed_pair;
        topic_pairs_due = {topic_pairs_due, pred};
    endtask

    always @(posedge i_clk) begin
        t_topic_pair due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (topic_pairs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer old=%0d new=%0d", o_old_topic, o_new_topic);
            end else begin
                due = topic_pairs_due.pop_front();
                if (due.old_topic !== o_old_topic || due.drawn_topic !== o_new_topic) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected old=%0d new=%0d, got old=%0d new=%0d",
                                 due.old_topic, due.drawn_topic, o_old_topic, o_new_topic);
                end
            end
        end
    end

    function automatic t_stim_row cfg_row(input t_reg_idx idx, input logic [31:0] val);
        t_stim_row r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.cmd = CMD_ASSIGN;
        r.doc = '0;
        r.slot = '0;
        r.word = '0;
        r.init = '0;
        r.frac = '0;
        r.typed = 1'b0;
        r.exp_old = '0;
        r.exp_new = '0;
        return r;
    endfunction

    function automatic t_stim_row item_row(input t_cmd cmd, input int doc, input int slot,
                                           input int word, input int init, input int frac,
                                           input bit typed, input int eo, input int en);
        t_stim_row r;
        r.kind = ROW_ITEM;
        r.reg_idx = REG_ALPHA;
        r.reg_val = '0;
        r.cmd = cmd;
        r.doc = 10'(doc);
        r.slot = 16'(slot);
        r.word = 12'(word);
        r.init = 8'(init);
        r.frac = 16'(frac);
        r.typed = typed;
        r.exp_old = 8'(eo);
        r.exp_new = 8'(en);
        return r;
    endfunction

    function automatic logic [23:0] pick_prior();
        case ($urandom_range(3))
            0: return 24'd1;
            1: return 24'hFFFFFF;
            2: return 24'd65536;
            default: return 24'($urandom_range(1, 24'hFFFFFF));
        endcase
    endfunction

    initial begin
        t_stim_row   rows[$];
        t_token      tok;
        logic [9:0]  doc_pool [4];
        logic [11:0] word_pool [6];
        int          roll;

        rows = {
            item_row(CMD_ASSIGN, 0, 0, 0, 255, 0, 1, 0, 255),
            item_row(CMD_ASSIGN, 1023, 65535, 4095, 0, 65535, 1, 0, 0),
            item_row(CMD_RESAMPLE, 1023, 65535, 4095, 9, 0, 1, 0, 0),
            item_row(CMD_RESAMPLE, 0, 0, 0, 0, 65535, 0, 0, 0),
            cfg_row(REG_NTOPICS, 0),
            item_row(CMD_ASSIGN, 3, 100, 9, 77, 0, 1, 0, 0),
            item_row(CMD_RESAMPLE, 3, 100, 9, 0, 40000, 1, 0, 0),
            cfg_row(REG_NTOPICS, 511),
            item_row(CMD_ASSIGN, 5, 101, 7, 200, 0, 1, 0, 200),
            cfg_row(REG_NTOPICS, 4),
            cfg_row(REG_VOCAB, 0),
            cfg_row(REG_ALPHA, 24'hFFFFFF),
            cfg_row(REG_BETA, 24'hFFFFFF),
            item_row(CMD_RESAMPLE, 5, 101, 7, 0, 65535, 0, 0, 0),
            item_row(CMD_ASSIGN, 6, 102, 1, 255, 0, 1, 0, 3),
            item_row(CMD_RESAMPLE, 999, 102, 1, 0, 32768, 0, 0, 0),
            cfg_row(REG_ALPHA, 1),
            cfg_row(REG_BETA, 1),
            cfg_row(REG_VOCAB, 4096),
            item_row(CMD_ASSIGN, 2, 0, 3, 1, 0, 1, 0, 1),
            item_row(CMD_RESAMPLE, 2, 0, 3, 0, 0, 1, 1, 0),
            item_row(CMD_RESAMPLE, 2, 0, 3, 0, 65535, 0, 0, 0),
            cfg_row(REG_VOCAB, 8191),
            cfg_row(REG_NTOPICS, 2),
            item_row(CMD_RESAMPLE, 1023, 65535, 4095, 0, 12345, 0, 0, 0),
            item_row(CMD_ASSIGN, 8, 200, 2, 1, 0, 1, 0, 1)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_token(rows[i].cmd, rows[i].doc, rows[i].slot, rows[i].word,
                           rows[i].init, rows[i].frac, rows[i].typed,
                           {rows[i].exp_old, rows[i].exp_new});
                if (rows[i].cmd == CMD_ASSIGN) begin
                    tok.slot = rows[i].slot;
                    tok.doc = rows[i].doc;
                    tok.word = rows[i].word;
                    live_tokens = {live_tokens, tok};
                end
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            tx_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 85 : 0;
            rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 24 : 0;
            write_reg(REG_ALPHA, pick_prior());
            write_reg(REG_BETA, pick_prior());
            write_reg(REG_NTOPICS, (ph == 5) ? 1 : $urandom_range(2, 8));
            case ($urandom_range(3))
                0: write_reg(REG_VOCAB, 1);
                1: write_reg(REG_VOCAB, 4096);
                2: write_reg(REG_VOCAB, 8191);
                default: write_reg(REG_VOCAB, $urandom_range(1, 4096));
            endcase
            foreach (doc_pool[j]) doc_pool[j] = 10'($urandom);
            foreach (word_pool[j]) word_pool[j] = 12'($urandom);
            for (int n = 0; n < 190; n++) begin
                if (ph == 1 && n == 95) wait_drained();
                roll = $urandom_range(99);
                if (roll < 35 || live_tokens.size() == 0) begin
                    tok = '{16'($urandom), doc_pool[$urandom_range(3)],
                            word_pool[$urandom_range(5)]};
                    send_token(CMD_ASSIGN, tok.doc, tok.slot, tok.word, 8'($urandom),
                               16'($urandom), 0, '0);
                    live_tokens = {live_tokens, tok};
                end else if (roll < 85) begin
                    tok = live_tokens[$urandom_range(live_tokens.size() - 1)];
                    send_token(CMD_RESAMPLE, tok.doc, tok.slot, tok.word, 8'($urandom),
                               16'($urandom), 0, '0);
                end else if (roll < 93) begin
                    tok = live_tokens[$urandom_range(live_tokens.size() - 1)];
                    send_token(CMD_RESAMPLE, 10'($urandom), tok.slot, 12'($urandom),
                               8'($urandom), 16'($urandom), 0, '0);
                end else begin
                    tok = '{16'($urandom), 10'($urandom), 12'($urandom)};
                    send_token(CMD_ASSIGN, tok.doc, tok.slot, tok.word, 8'($urandom),
                               16'($urandom), 0, '0);
                    live_tokens = {live_tokens, tok};
                end
            end
        end

        i_in_valid <= 1'b0;
        while (topic_pairs_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("lda_collapsed_gibbs_token_sampler_unit test passed");
        else
            $display("lda_collapsed_gibbs_token_sampler_unit test failed");
        $finish;
    end
endmodule
